// ----- rtl/fau_pkg.sv -----
package fau_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_FILTERED    = 3'd0,
    ST_LOST        = 3'd1,
    ST_NEW         = 3'd2,
    ST_MERGED      = 3'd3,
    ST_DRAINED     = 3'd4,
    ST_DRAIN_LAST  = 3'd5,
    ST_DRAIN_EMPTY = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_DRAIN
  } fsm_t;

  localparam logic CMD_ACCOUNT = 1'b0;
  localparam logic CMD_DRAIN   = 1'b1;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam logic [1:0] FILT_ALL = 2'd0;
  localparam logic [1:0] FILT_V4  = 2'd1;
  localparam logic [1:0] FILT_V6  = 2'd2;

  localparam logic [7:0] PROTO_NONE = 8'hff;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FAMILY_FILTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_PROTOCOL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_PORTS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUMP_MARGIN   = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  family;
    logic [7:0]  protocol;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] pkt_length;
    logic [12:0] frag_offset;
    logic [15:0] l4_src_port;
    logic [15:0] l4_dst_port;
  } fau_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        need_dump;
    logic [31:0] lost_total;
    logic        flow_family;
    logic [7:0]  flow_protocol;
    logic [63:0] flow_src_hi;
    logic [63:0] flow_src_lo;
    logic [63:0] flow_dst_hi;
    logic [63:0] flow_dst_lo;
    logic [15:0] flow_src_port;
    logic [15:0] flow_dst_port;
    logic [63:0] flow_bytes;
  } fau_out_t;

  // stored flow key
  typedef struct packed {
    logic        family;
    logic [7:0]  protocol;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } fau_key_t;

endpackage

// ----- rtl/fau_in_if.sv -----
interface fau_in_if import fau_pkg::*; ();
  logic    valid;
  logic    ready;
  fau_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/fau_out_if.sv -----
interface fau_out_if import fau_pkg::*; ();
  logic     valid;
  logic     ready;
  fau_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ip_flow_byte_accounting_unit.sv -----
// IP flow byte accounting. Each packet transfer on in_ch carries parsed
// IPv4/IPv6 header fields; the unit filters on family, builds a flow key and
// scans the flow table in slot order, one stored entry per cycle, out of a
// synchronous key memory. A hit adds the packet length to the flow's 64-bit
// byte total, a miss appends the flow, a full table bumps the lost counter.
// A drain command (cmd=1) returns one stored flow per transfer in slot order
// and empties the table after the last one. Every item returns exactly one
// result on out_ch. Items are handled one at a time: filtered, lost, empty
// drain and first-flow items are settled in the decide state after the
// accept, a drain of a stored flow adds a memory read, and a lookup scans
// entries in slot order, up to the number of flows stored, through the
// single read port of the key memory. A waiting result holds the item in
// its last cycle until out_ch frees up. The result register lets the next
// item be accepted while a result waits. Tables start empty after reset,
// no clearing pass. Configuration writes (cfg_we, cfg_idx, cfg_wdata) are
// to be done while the unit is idle.
module ip_flow_byte_accounting_unit import fau_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fau_in_if.sink                in_ch,
  fau_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int KW = $bits(fau_key_t);

  // configuration
  logic [1:0]  family_filter_r;
  logic        keep_protocol_r;
  logic        keep_ports_r;
  logic [10:0] table_limit_r;
  logic [6:0]  dump_margin_r;

  // table state
  fsm_t          state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] dptr_r, dptr_nxt;
  logic [31:0]   lost_r, lost_nxt;
  logic          dump_r, dump_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  // latched item
  logic          cmd_r;
  logic          pass_r;
  logic [1:0]    fam_r;
  logic [15:0]   len_r;
  fau_key_t      key_r;

  logic          pass_c;
  fau_key_t      key_c;

  // result register
  logic          out_valid_r;
  fau_out_t      out_data_r;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [KW-1:0] key_rdata;
  fau_key_t      key_rd;
  logic [63:0]   bytes_wdata;
  logic [63:0]   bytes_rdata;

  logic          accept;
  logic          out_free;
  logic          fin;
  logic          emit;
  logic [CW-1:0] limit_eff;
  logic          full;
  logic [CW-1:0] dsel;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] used_after;
  fau_out_t      res;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = fin && out_free;
  assign key_rd   = fau_key_t'(key_rdata);

  assign limit_eff = ({21'd0, table_limit_r} > 32'(TABLE_DEPTH)) ?
                     CW'(TABLE_DEPTH) : CW'(table_limit_r);
  assign full      = used_r >= limit_eff;
  assign dsel      = (dptr_r >= used_r) ? used_r - 1'b1 : dptr_r;
  assign idx_inc   = CW'(idx_r) + 1'b1;

  fau_key u_key (
    .pkt           (in_ch.data),
    .family_filter (family_filter_r),
    .keep_protocol (keep_protocol_r),
    .keep_ports    (keep_ports_r),
    .pass          (pass_c),
    .key           (key_c)
  );

  // key and byte totals share address and write enable
  fau_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (key_r),
    .raddr (mem_raddr),
    .rdata (key_rdata)
  );

  fau_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_bytes_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (bytes_wdata),
    .raddr (mem_raddr),
    .rdata (bytes_rdata)
  );

  // datapath and result forming
  always_comb begin
    fin         = 1'b0;
    res         = '0;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    bytes_wdata = 64'(len_r);
    mem_raddr   = idx_r;
    idx_nxt     = idx_r;
    used_nxt    = used_r;
    dptr_nxt    = dptr_r;
    lost_nxt    = lost_r;
    dump_nxt    = dump_r;
    used_after  = used_r;
    unique case (state_r)
      S_IDLE: begin
      end
      S_DECIDE: begin
        if (cmd_r == CMD_DRAIN) begin
          if (used_r == '0) begin
            fin        = 1'b1;
            res.status = ST_DRAIN_EMPTY;
          end else begin
            mem_raddr = dsel[AW-1:0];
            idx_nxt   = dsel[AW-1:0];
          end
        end else if (!pass_r) begin
          fin        = 1'b1;
          res.status = ST_FILTERED;
        end else if (full) begin
          fin        = 1'b1;
          res.status = ST_LOST;
          if (out_free) lost_nxt = lost_r + 1'b1;
        end else if (fam_r != FAM_V4 && fam_r != FAM_V6) begin
          fin        = 1'b1;
          res.status = ST_FILTERED;
        end else if (used_r == '0) begin
          // first flow: append without a scan
          fin        = 1'b1;
          res.status = ST_NEW;
        end else begin
          mem_raddr = '0;
          idx_nxt   = '0;
        end
      end
      S_SEARCH: begin
        if (key_rd == key_r) begin
          fin         = 1'b1;
          res.status  = ST_MERGED;
          bytes_wdata = bytes_rdata + 64'(len_r);
          mem_waddr   = idx_r;
          mem_we      = emit;
        end else if (idx_inc >= used_r) begin
          fin        = 1'b1;
          res.status = ST_NEW;
        end else begin
          mem_raddr = idx_inc[AW-1:0];
          idx_nxt   = idx_inc[AW-1:0];
        end
      end
      S_DRAIN: begin
        fin = 1'b1;
        if (idx_inc >= used_r) begin
          res.status = ST_DRAIN_LAST;
          if (out_free) begin
            used_nxt = '0;
            dptr_nxt = '0;
            dump_nxt = 1'b0;
          end
        end else begin
          res.status = ST_DRAINED;
          if (out_free) dptr_nxt = idx_inc;
        end
      end
      default: begin
      end
    endcase

    // append a new flow at the end of the table
    if (res.status == ST_NEW) begin
      mem_waddr   = used_r[AW-1:0];
      bytes_wdata = 64'(len_r);
      mem_we      = emit;
      used_after  = used_r + 1'b1;
      if (out_free) used_nxt = used_after;
    end

    if (res.status == ST_NEW || res.status == ST_MERGED) begin
      res.flow_family   = key_r.family;
      res.flow_protocol = key_r.protocol;
      res.flow_src_hi   = key_r.src_hi;
      res.flow_src_lo   = key_r.src_lo;
      res.flow_dst_hi   = key_r.dst_hi;
      res.flow_dst_lo   = key_r.dst_lo;
      res.flow_src_port = key_r.src_port;
      res.flow_dst_port = key_r.dst_port;
      res.flow_bytes    = bytes_wdata;
      if (out_free && (SW'(used_after) + SW'(dump_margin_r) >= SW'(limit_eff))) begin
        dump_nxt = 1'b1;
      end
    end else if (res.status == ST_DRAINED || res.status == ST_DRAIN_LAST) begin
      res.flow_family   = key_rd.family;
      res.flow_protocol = key_rd.protocol;
      res.flow_src_hi   = key_rd.src_hi;
      res.flow_src_lo   = key_rd.src_lo;
      res.flow_dst_hi   = key_rd.dst_hi;
      res.flow_dst_lo   = key_rd.dst_lo;
      res.flow_src_port = key_rd.src_port;
      res.flow_dst_port = key_rd.dst_port;
      res.flow_bytes    = bytes_rdata;
    end

    res.need_dump  = dump_nxt;
    res.lost_total = lost_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (fin) begin
          if (out_free) state_nxt = S_IDLE;
        end else if (cmd_r == CMD_DRAIN) begin
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: if (emit) state_nxt = S_IDLE;
      S_DRAIN:  if (emit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      used_r          <= '0;
      dptr_r          <= '0;
      lost_r          <= '0;
      dump_r          <= 1'b0;
      out_valid_r     <= 1'b0;
      family_filter_r <= FILT_ALL;
      keep_protocol_r <= 1'b1;
      keep_ports_r    <= 1'b1;
      table_limit_r   <= 11'd1024;
      dump_margin_r   <= 7'd64;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      dptr_r  <= dptr_nxt;
      lost_r  <= lost_nxt;
      dump_r  <= dump_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_FAMILY_FILTER: family_filter_r <= cfg_wdata[1:0];
          REG_KEEP_PROTOCOL: keep_protocol_r <= cfg_wdata[0];
          REG_KEEP_PORTS:    keep_ports_r    <= cfg_wdata[0];
          REG_TABLE_LIMIT:   table_limit_r   <= cfg_wdata;
          REG_DUMP_MARGIN:   dump_margin_r   <= cfg_wdata[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      cmd_r  <= in_ch.data.cmd;
      pass_r <= pass_c;
      fam_r  <= in_ch.data.family;
      len_r  <= in_ch.data.pkt_length;
      key_r  <= key_c;
    end
    if (emit) begin
      out_data_r <= res;
    end
  end
endmodule

// ----- rtl/fau_ram.sv -----
module fau_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/fau_key.sv -----
module fau_key import fau_pkg::*; (
  input  fau_in_t    pkt,
  input  logic [1:0] family_filter,
  input  logic       keep_protocol,
  input  logic       keep_ports,
  output logic       pass,
  output fau_key_t   key
);
  logic [7:0] proto;
  logic       ports_ok;

  assign pass = (family_filter == FILT_ALL) ||
                (family_filter == FILT_V4 && pkt.family == FAM_V4) ||
                (family_filter == FILT_V6 && pkt.family == FAM_V6);

  always_comb begin
    key = '0;
    key.family = pkt.family[0];
    if (pkt.family == FAM_V4) begin
      key.src_lo = {32'd0, pkt.src_addr_lo[31:0]};
      key.dst_lo = {32'd0, pkt.dst_addr_lo[31:0]};
      proto      = keep_protocol ? pkt.protocol : PROTO_NONE;
      ports_ok   = (pkt.frag_offset == '0);
    end else begin
      key.src_hi = pkt.src_addr_hi;
      key.src_lo = pkt.src_addr_lo;
      key.dst_hi = pkt.dst_addr_hi;
      key.dst_lo = pkt.dst_addr_lo;
      proto      = pkt.protocol;
      ports_ok   = 1'b1;
    end
    key.protocol = proto;
    if (ports_ok && keep_protocol && keep_ports &&
        (proto == PROTO_TCP || proto == PROTO_UDP)) begin
      key.src_port = pkt.l4_src_port;
      key.dst_port = pkt.l4_dst_port;
    end
  end
endmodule

// ----- rtl/fau_checker.sv -----
module fau_checker import fau_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input fau_out_t out_data
);
  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // no flow reported for filtered, lost or empty drain
  a_no_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FILTERED || out_data.status == ST_LOST ||
                  out_data.status == ST_DRAIN_EMPTY)
    |-> out_data.flow_bytes == '0 && out_data.flow_src_port == '0 &&
        out_data.flow_dst_port == '0 && out_data.flow_family == 1'b0)
    else $error("flow fields set without a flow");

  // last drain clears the dump flag
  a_dump_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DRAIN_LAST |-> !out_data.need_dump)
    else $error("need_dump still set after last drain");
endmodule

bind ip_flow_byte_accounting_unit fau_checker u_fau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- tb/sv/testbench.sv -----
module testbench;
  import fau_pkg::*;

  // Flow table predictor plus the queue of results still owed by the unit.
  class flow_scoreboard;
    fau_key_t    keys[1024];
    logic [63:0] bytes[1024];
    int          used_n;
    int          drain_ptr;
    logic [31:0] lost_cnt;
    logic        dump_flag;
    logic [1:0]  filt;
    logic        keep_proto;
    logic        keep_port;
    logic [10:0] tbl_limit;
    logic [6:0]  margin;
    fau_out_t    owed[$];
    int          errors;

    function new();
      used_n = 0; drain_ptr = 0; lost_cnt = '0; dump_flag = 1'b0;
      filt = FILT_ALL; keep_proto = 1'b1; keep_port = 1'b1;
      tbl_limit = 11'd1024; margin = 7'd64;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_FAMILY_FILTER: filt = v[1:0];
        REG_KEEP_PROTOCOL: keep_proto = v[0];
        REG_KEEP_PORTS:    keep_port = v[0];
        REG_TABLE_LIMIT:   tbl_limit = v[10:0];
        REG_DUMP_MARGIN:   margin = v[6:0];
        default: ;
      endcase
    endfunction

    function void report(int slot, ref fau_out_t r);
      r.flow_family   = keys[slot].family;
      r.flow_protocol = keys[slot].protocol;
      r.flow_src_hi   = keys[slot].src_hi;
      r.flow_src_lo   = keys[slot].src_lo;
      r.flow_dst_hi   = keys[slot].dst_hi;
      r.flow_dst_lo   = keys[slot].dst_lo;
      r.flow_src_port = keys[slot].src_port;
      r.flow_dst_port = keys[slot].dst_port;
      r.flow_bytes    = bytes[slot];
    endfunction

    // predicts the result of one accepted input transfer
    function void note_input(fau_in_t it);
      fau_out_t   r;
      fau_key_t   k;
      logic [7:0] proto;
      logic       port_ok;
      int         lim;
      int         i;
      r = '0;
      k = '0;
      lim = (tbl_limit > 11'd1024) ? 1024 : int'(tbl_limit);
      if (it.cmd == CMD_DRAIN) begin
        if (used_n == 0) begin
          r.status = ST_DRAIN_EMPTY;
        end else begin
          if (drain_ptr >= used_n) drain_ptr = used_n - 1;
          report(drain_ptr, r);
          drain_ptr++;
          if (drain_ptr >= used_n) begin
            r.status = ST_DRAIN_LAST;
            used_n = 0; drain_ptr = 0; dump_flag = 1'b0;
          end else begin
            r.status = ST_DRAINED;
          end
        end
      end else if (filt != FILT_ALL &&
                   !((filt == FILT_V4 && it.family == FAM_V4) ||
                     (filt == FILT_V6 && it.family == FAM_V6))) begin
        r.status = ST_FILTERED;
      end else if (used_n >= lim) begin
        lost_cnt++;
        r.status = ST_LOST;
      end else if (it.family > FAM_V6) begin
        r.status = ST_FILTERED;
      end else begin
        proto = it.protocol;
        k.family = it.family[0];
        if (it.family == FAM_V4) begin
          k.src_lo = {32'd0, it.src_addr_lo[31:0]};
          k.dst_lo = {32'd0, it.dst_addr_lo[31:0]};
          if (!keep_proto) proto = PROTO_NONE;
          port_ok = (it.frag_offset == 13'd0);
        end else begin
          k.src_hi = it.src_addr_hi;
          k.src_lo = it.src_addr_lo;
          k.dst_hi = it.dst_addr_hi;
          k.dst_lo = it.dst_addr_lo;
          port_ok = 1'b1;
        end
        k.protocol = proto;
        if (port_ok && keep_proto && keep_port && (proto == PROTO_TCP || proto == PROTO_UDP)) begin
          k.src_port = it.l4_src_port;
          k.dst_port = it.l4_dst_port;
        end
        for (i = 0; i < used_n; i++)
          if (keys[i] == k) break;
        if (i < used_n) begin
          bytes[i] = bytes[i] + 64'(it.pkt_length);
          r.status = ST_MERGED;
        end else begin
          i = used_n;
          keys[i] = k;
          bytes[i] = 64'(it.pkt_length);
          used_n++;
          r.status = ST_NEW;
        end
        report(i, r);
        if (used_n + int'(margin) >= lim) dump_flag = 1'b1;
      end
      r.need_dump  = dump_flag;
      r.lost_total = lost_cnt;
      owed.push_back(r);
    endfunction

    function void cmp(string fld, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", fld, e, a);
        errors++;
      end
    endfunction

    function void check_result(fau_out_t a);
      fau_out_t e;
      if (owed.size() == 0) begin
        $error("result transfer with no pending prediction");
        errors++;
        return;
      end
      e = owed.pop_front();
      cmp("status", 64'(e.status), 64'(a.status));
      cmp("need_dump", 64'(e.need_dump), 64'(a.need_dump));
      cmp("lost_total", 64'(e.lost_total), 64'(a.lost_total));
      cmp("flow_family", 64'(e.flow_family), 64'(a.flow_family));
      cmp("flow_protocol", 64'(e.flow_protocol), 64'(a.flow_protocol));
      cmp("flow_src_hi", e.flow_src_hi, a.flow_src_hi);
      cmp("flow_src_lo", e.flow_src_lo, a.flow_src_lo);
      cmp("flow_dst_hi", e.flow_dst_hi, a.flow_dst_hi);
      cmp("flow_dst_lo", e.flow_dst_lo, a.flow_dst_lo);
      cmp("flow_src_port", 64'(e.flow_src_port), 64'(a.flow_src_port));
      cmp("flow_dst_port", 64'(e.flow_dst_port), 64'(a.flow_dst_port));
      cmp("flow_bytes", e.flow_bytes, a.flow_bytes);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  fau_in_if  in_ch();
  fau_out_if out_ch();

  flow_scoreboard sb = new();

  // receiver hold-off request, serviced by the receiver process
  bit hold_req = 0;
  int burst_left = 0;

  // pool of flows so that many packets merge into existing entries
  logic [63:0] pool_addr[32][4];
  logic [15:0] pool_port[32][2];
  logic [7:0]  pool_proto[32];

  always #5 clk = ~clk;

  ip_flow_byte_accounting_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // monitors: transfers are sampled at the rising edge, before any new drive
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // receiver: stall pattern chosen at random from four modes; long hold-off on request
  initial begin
    int mode;
    int cnt;
    out_ch.ready <= 1'b0;
    mode = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req = 0;
        repeat (300) @(posedge clk);
      end else begin
        if (cnt == 0) begin
          mode = $urandom_range(0, 3);
          cnt = 64;
        end
        cnt--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= ($urandom_range(0, 9) < 8);
          default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
  end

  // sender: bursts of random length separated by random gaps
  task automatic send(fau_in_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come back;
  // it first waits on the clock so the last accepted transfer is already noted
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int f, int kp, int kq, int lim, int mg);
    wait_quiet();
    cfg_we <= 1'b1; cfg_idx <= REG_FAMILY_FILTER; cfg_wdata <= CFG_DATA_W'(f);
    sb.set_reg(REG_FAMILY_FILTER, CFG_DATA_W'(f));
    @(posedge clk);
    cfg_idx <= REG_KEEP_PROTOCOL; cfg_wdata <= CFG_DATA_W'(kp);
    sb.set_reg(REG_KEEP_PROTOCOL, CFG_DATA_W'(kp));
    @(posedge clk);
    cfg_idx <= REG_KEEP_PORTS; cfg_wdata <= CFG_DATA_W'(kq);
    sb.set_reg(REG_KEEP_PORTS, CFG_DATA_W'(kq));
    @(posedge clk);
    cfg_idx <= REG_TABLE_LIMIT; cfg_wdata <= CFG_DATA_W'(lim);
    sb.set_reg(REG_TABLE_LIMIT, CFG_DATA_W'(lim));
    @(posedge clk);
    cfg_idx <= REG_DUMP_MARGIN; cfg_wdata <= CFG_DATA_W'(mg);
    sb.set_reg(REG_DUMP_MARGIN, CFG_DATA_W'(mg));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fau_in_t rand_fields();
    fau_in_t it;
    it.cmd         = CMD_ACCOUNT;
    it.family      = 2'($urandom_range(0, 3));
    it.protocol    = 8'($urandom_range(0, 255));
    it.src_addr_hi = {$urandom, $urandom};
    it.src_addr_lo = {$urandom, $urandom};
    it.dst_addr_hi = {$urandom, $urandom};
    it.dst_addr_lo = {$urandom, $urandom};
    it.pkt_length  = 16'($urandom_range(0, 65535));
    it.frag_offset = 13'($urandom_range(0, 8191));
    it.l4_src_port = 16'($urandom_range(0, 65535));
    it.l4_dst_port = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  // mostly pooled flows with random payload fields, some fresh flows and noise
  function automatic fau_in_t gen_packet();
    fau_in_t it;
    int p;
    it = rand_fields();
    it.family = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 8) begin
      p = $urandom_range(0, 31);
      it.src_addr_hi = pool_addr[p][0];
      it.src_addr_lo = pool_addr[p][1];
      it.dst_addr_hi = pool_addr[p][2];
      it.dst_addr_lo = pool_addr[p][3];
      it.l4_src_port = pool_port[p][0];
      it.l4_dst_port = pool_port[p][1];
      it.protocol    = pool_proto[p];
    end else begin
      case ($urandom_range(0, 2))
        0: it.protocol = PROTO_TCP;
        1: it.protocol = PROTO_UDP;
        default: ;
      endcase
    end
    if ($urandom_range(0, 9) < 7) it.frag_offset = '0;
    return it;
  endfunction

  task automatic send_drain();
    fau_in_t it;
    it = rand_fields();
    it.cmd = CMD_DRAIN;
    send(it);
  endtask

  // drain every stored flow, then one more on the empty table
  task automatic drain_all();
    int guard;
    guard = 0;
    while (sb.used_n != 0 && guard < 1100) begin
      send_drain();
      guard++;
    end
    send_drain();
  endtask

  task automatic random_phase(int n, int drain_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < drain_pct) send_drain();
      else if ($urandom_range(0, 99) == 0) drain_all();
      else send(gen_packet());
    end
  endtask

  initial begin
    fau_in_t it;
    int k;
    for (int p = 0; p < 32; p++) begin
      for (int a = 0; a < 4; a++) pool_addr[p][a] = {$urandom, $urandom};
      pool_port[p][0] = 16'($urandom_range(0, 65535));
      pool_port[p][1] = 16'($urandom_range(0, 65535));
      case (p % 4)
        0: pool_proto[p] = PROTO_TCP;
        1: pool_proto[p] = PROTO_UDP;
        2: pool_proto[p] = PROTO_NONE;
        default: pool_proto[p] = 8'($urandom_range(0, 255));
      endcase
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset configuration
    send_drain();                         // drain on empty table
    it = '0; send(it);                    // all-zero IPv4 packet
    it = '1; it.cmd = CMD_ACCOUNT; it.family = FAM_V4; send(it);
    it = '1; it.cmd = CMD_ACCOUNT; it.family = FAM_V6; send(it);
    send(it);                             // same IPv6 flow again: merge
    it = '1; it.cmd = CMD_ACCOUNT; it.family = 2'd2; send(it);   // unknown family
    it = '1; it.cmd = CMD_ACCOUNT; it.family = 2'd3; send(it);
    it = rand_fields(); it.family = FAM_V4; it.protocol = PROTO_TCP; it.frag_offset = '0;
    send(it);
    send(it);                             // merge into the TCP flow
    it.frag_offset = 13'h1fff; send(it);  // fragment drops the ports
    it.protocol = PROTO_UDP; it.frag_offset = '0; send(it);
    it = rand_fields(); it.family = FAM_V6; it.protocol = PROTO_UDP; it.frag_offset = 13'h5;
    send(it);                             // IPv6 ignores the fragment offset
    it.protocol = 8'd1; send(it);
    send_drain();
    send_drain();
    drain_all();

    // ports off, protocol off, filters
    set_config(FILT_V4, 0, 1, 65, 0);
    random_phase(150, 5);
    set_config(FILT_V6, 1, 0, 100, 64);
    random_phase(150, 5);

    // long receiver hold-off while the sender keeps offering
    hold_req = 1;
    random_phase(40, 0);
    wait_quiet();                         // sender pause until all results are in

    // limit zero: every accepted packet is lost
    set_config(FILT_ALL, 1, 1, 0, 5);
    random_phase(60, 5);
    // filter value three accepts nothing
    set_config(2'd3, 1, 1, 300, 10);
    random_phase(60, 10);
    // limit above the table depth is clamped
    set_config(FILT_ALL, 1, 1, 2047, 127);
    random_phase(200, 2);
    // fill, then lower the limit below the stored count
    set_config(FILT_ALL, 1, 1, 200, 20);
    for (k = 0; k < 120; k++) begin
      it = gen_packet();
      it.family = FAM_V6;
      it.src_addr_lo = 64'(k);
      send(it);
    end
    set_config(FILT_ALL, 0, 0, 65, 64);
    random_phase(150, 3);
    drain_all();

    // small table fills up: losses and dump flag
    set_config(FILT_ALL, 1, 1, 65, 30);
    for (k = 0; k < 100; k++) begin
      it = gen_packet();
      it.family = 2'($urandom_range(0, 1));
      send(it);
    end
    drain_all();

    for (k = 0; k < 5; k++) begin
      set_config($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(65, 400), $urandom_range(0, 64));
      random_phase(80, 6);
    end
    set_config(FILT_ALL, 1, 1, 1024, 64);
    random_phase(100, 4);
    drain_all();

    wait_quiet();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("** ip_flow_byte_accounting_unit: PASSED **");
    end else begin
      $display("** ip_flow_byte_accounting_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("** ip_flow_byte_accounting_unit: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fau_pkg.sv
rtl/fau_in_if.sv
rtl/fau_out_if.sv
rtl/fau_ram.sv
rtl/fau_key.sv
rtl/ip_flow_byte_accounting_unit.sv
rtl/fau_checker.sv
tb/sv/testbench.sv
